// ----- hdl/rmte_pkg.sv -----
package rmte_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES  = 32;
    localparam int IDX_W          = 5;
    localparam int CNT_W          = 6;
    localparam int MAP_PAGE_SHIFT = 16;

    // Request codes.
    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_REM   = 3'd1;
    localparam logic [2:0] REQ_PROT  = 3'd2;
    localparam logic [2:0] REQ_PAGE  = 3'd3;
    localparam logic [2:0] REQ_TOP   = 3'd4;
    localparam logic [2:0] REQ_ABOVE = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISALIGN = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_EMPTIED  = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] req_addr;
        logic [31:0] length_bytes;
        logic [2:0]  prot_bits;
        logic [7:0]  map_flags;
        logic [7:0]  desc_id;
        logic [1:0]  desc_access;
        logic [47:0] file_offset;
        logic [47:0] backing_size;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_addr;
        logic [31:0] region_length;
        logic [2:0]  region_prot;
        logic [7:0]  region_flags;
        logic [7:0]  region_desc;
        logic [47:0] region_offset;
        logic [47:0] region_file_size;
    } t_res;

    // One region: attrs hold prot 2:0, flags 10:3, desc 18:11, access 20:19.
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] size;
        logic [20:0] attrs;
        logic [47:0] off;
        logic [47:0] fsz;
    } t_entry;

    // Chain control: shift toward cell 0 and/or load a piece at a slot.
    typedef struct packed {
        logic             pop;
        logic             app;
        logic [CNT_W-1:0] widx;
    } t_ctl;

    // Highest protection a region may be given.
    function automatic logic [2:0] max_prot(input logic [20:0] at);
        logic [2:0] mp;
        mp = 3'd3;
        if (at[18:11] != 8'd0 && !at[4]) begin
            case (at[20:19])
                2'd0:    mp = 3'd1;
                2'd1:    mp = 3'd2;
                2'd2:    mp = 3'd3;
                default: mp = 3'd0;
            endcase
        end
        return mp;
    endfunction

endpackage

// ----- hdl/region_map_table_engine.sv -----
// A rejected request answers in the cycle after start. Lookups and full-table rejects
// answer after one rotation of the table (S_DRY); updates rotate it and then rebuild it
// (S_WET), popping each old region and appending its pieces plus the inserted region.
// One request at a time; busy is high while it runs.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset (synchronous, active low) empties the table and sets page_shift to 12.
module region_map_table_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rmte_pkg::t_req i_req,
    output logic           o_valid,
    output rmte_pkg::t_res o_res,
    input  logic           i_cfg_we,
    input  logic [4:0]     i_cfg_data
);
    import rmte_pkg::*;

    logic [4:0] r_page_shift;
    t_ctl       w_ctl;
    t_entry     w_piece;
    t_entry     w_q [TABLE_ENTRIES];

    // Page size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= 5'd12;
        end else if (i_cfg_we) begin
            r_page_shift <= i_cfg_data;
        end
    end

    // Row of region cells; each shifts toward cell 0.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        rmte_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_right ((g == TABLE_ENTRIES - 1) ? w_piece : w_q[(g + 1) % TABLE_ENTRIES]),
            .i_piece (w_piece),
            .o_q     (w_q[g])
        );
    end

    rmte_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (i_req),
        .i_page_shift (r_page_shift),
        .i_head       (w_q[0]),
        .o_ctl        (w_ctl),
        .o_piece      (w_piece),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_res        (o_res)
    );

endmodule

// ----- hdl/rmte_cell.sv -----
module rmte_cell (
    input  logic                             i_clk,
    input  logic [rmte_pkg::IDX_W-1:0]       i_idx,
    input  rmte_pkg::t_ctl                   i_ctl,
    input  rmte_pkg::t_entry                 i_right,
    input  rmte_pkg::t_entry                 i_piece,
    output rmte_pkg::t_entry                 o_q
);
    import rmte_pkg::*;

    logic [CNT_W-1:0] w_pos;
    logic             w_ld;
    t_entry           r_q;

    assign w_pos = {1'b0, i_idx};

    // On a shift the loaded slot sits one place lower.
    assign w_ld = i_ctl.app && (i_ctl.pop ? (w_pos + CNT_W'(1) == i_ctl.widx)
                                          : (w_pos == i_ctl.widx));

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_q <= i_piece;
        end else if (i_ctl.pop) begin
            r_q <= i_right;
        end
    end

    assign o_q = r_q;

endmodule

// ----- hdl/rmte_ctrl.sv -----
module rmte_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rmte_pkg::t_req   i_req,
    input  logic [4:0]       i_page_shift,
    input  rmte_pkg::t_entry i_head,
    output rmte_pkg::t_ctl   o_ctl,
    output rmte_pkg::t_entry o_piece,
    output logic             o_busy,
    output logic             o_valid,
    output rmte_pkg::t_res   o_res
);
    import rmte_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DRY  = 2'd1;
    localparam logic [1:0] S_WET  = 2'd2;
    localparam logic [33:0] MAP_MASK = 34'((64'd1 << MAP_PAGE_SHIFT) - 64'd1);

    logic [1:0]       r_state, n_state;
    t_req             r_req, n_req;
    t_res             r_res, n_res;
    logic             r_valid, n_valid;
    logic [32:0]      r_s, n_s;
    logic [32:0]      r_e, n_e;
    logic [32:0]      r_cs, n_cs;
    logic [CNT_W-1:0] r_vc, n_vc;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_npc, n_npc;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_prod, n_prod;
    logic [1:0]       r_k, n_k;
    logic             r_stop, n_stop;
    logic             r_ins, n_ins;
    logic             r_cov_done, n_cov_done;
    logic             r_cov_ok, n_cov_ok;
    logic             r_found, n_found;
    logic             r_have_prev, n_have_prev;
    logic [33:0]      r_prev, n_prev;

    // Piece generation for the entry at the head of the chain.
    logic [32:0] w_base, w_pe;
    logic [1:0]  c_np;
    t_entry      c_pc0, c_pc1, c_pc2, c_sel;
    logic [32:0] c_s_next;
    logic        c_stop_next;
    logic [20:0] w_na;
    t_entry      w_new;

    assign w_base = {1'b0, i_head.base};
    assign w_pe   = w_base + {1'b0, i_head.size};
    assign w_na   = {i_head.attrs[20:3], r_req.prot_bits};
    assign w_new  = '{base: r_req.req_addr, size: r_req.length_bytes,
                      attrs: {r_req.desc_access, r_req.desc_id, r_req.map_flags,
                              r_req.prot_bits},
                      off: r_req.file_offset, fsz: r_req.backing_size};

    always_comb begin
        t_entry hd_cut, tl_cut;
        hd_cut = i_head;
        hd_cut.size = r_s[31:0] - i_head.base;
        tl_cut = i_head;
        tl_cut.base = r_e[31:0];
        tl_cut.size = 32'(w_pe - r_e);
        tl_cut.off  = i_head.off + {15'd0, r_e - w_base};
        c_np = 2'd1;
        c_pc0 = i_head;
        c_pc1 = i_head;
        c_pc2 = i_head;
        c_s_next = r_s;
        c_stop_next = r_stop;
        if (r_req.req_type == REQ_PROT) begin
            // Protection change: split off the head and tail parts.
            if (r_stop || r_s == r_e) begin
                c_np = 2'd1;
            end else if (w_base < r_s && r_e < w_pe) begin
                c_np = 2'd3;
                c_pc0 = hd_cut;
                c_pc1 = '{base: r_s[31:0], size: 32'(r_e - r_s), attrs: w_na,
                          off: i_head.off + {15'd0, r_s - w_base}, fsz: i_head.fsz};
                c_pc2 = tl_cut;
                c_stop_next = 1'b1;
            end else if (w_base < r_s && r_s < w_pe) begin
                c_np = 2'd2;
                c_pc0 = hd_cut;
                c_pc1 = '{base: r_s[31:0], size: 32'(w_pe - r_s), attrs: w_na,
                          off: i_head.off + {15'd0, r_s - w_base}, fsz: i_head.fsz};
                c_s_next = w_pe;
            end else if (w_base < r_e && r_e < w_pe) begin
                c_np = 2'd2;
                c_pc0 = '{base: r_s[31:0], size: 32'(r_e - r_s), attrs: w_na,
                          off: i_head.off, fsz: i_head.fsz};
                c_pc1 = tl_cut;
                c_stop_next = 1'b1;
            end else if (r_s <= w_base && w_pe <= r_e) begin
                c_np = 2'd1;
                c_pc0.attrs = w_na;
                c_s_next = w_pe;
            end
        end else begin
            // Add and remove: cut the request range out of the region.
            if (r_stop) begin
                c_np = 2'd1;
            end else if (w_base < r_s && r_e < w_pe) begin
                c_np = 2'd2;
                c_pc0 = hd_cut;
                c_pc1 = tl_cut;
                c_stop_next = 1'b1;
            end else if (w_base < r_s && r_s < w_pe) begin
                c_pc0 = hd_cut;
            end else if (w_base < r_e && r_e < w_pe) begin
                c_pc0 = tl_cut;
                c_stop_next = 1'b1;
            end else if (r_s <= w_base && w_pe <= r_e) begin
                c_np = 2'd0;
            end
        end
        case (r_k)
            2'd0:    c_sel = c_pc0;
            2'd1:    c_sel = c_pc1;
            default: c_sel = c_pc2;
        endcase
    end

    // Request checks and the sequencer.
    always_comb begin
        logic [31:0] pmask;
        logic        bad, bad_n, over, early;
        logic [2:0]  code;
        logic [32:0] sum;
        logic [33:0] cb, pe_r, sp;
        pmask = ~(32'hFFFF_FFFF << i_page_shift);
        sum   = {1'b0, i_req.req_addr} + {1'b0, i_req.length_bytes};
        bad   = ((i_req.req_addr & pmask) != 32'd0) ||
                ((i_req.length_bytes & pmask) != 32'd0);
        bad_n = (i_req.length_bytes == 32'd0) ||
                (({2'b0, i_req.length_bytes} & MAP_MASK) != 34'd0);
        over  = sum[32] && (sum[31:0] != 32'd0);
        early = 1'b0;
        code  = ST_MISALIGN;
        case (i_req.req_type)
            REQ_ADD:   early = bad || i_req.length_bytes == 32'd0 || over;
            REQ_REM:   early = bad || i_req.length_bytes == 32'd0;
            REQ_PROT:  early = bad;
            REQ_PAGE:  early = (i_req.req_addr & pmask) != 32'd0;
            REQ_TOP:   early = bad_n;
            REQ_ABOVE: early = bad_n ||
                               (({2'b0, i_req.req_addr} & MAP_MASK) != 34'd0);
            default: begin
                early = 1'b1;
                code  = ST_NONE;
            end
        endcase
        cb   = {2'b0, i_head.base} & ~MAP_MASK;
        pe_r = ({1'b0, w_pe} + MAP_MASK) & ~MAP_MASK;
        sp   = ({1'b0, r_s} > r_prev) ? {1'b0, r_s} : r_prev;

        n_state = r_state;  n_req = r_req;  n_res = r_res;  n_valid = 1'b0;
        n_s = r_s;  n_e = r_e;  n_cs = r_cs;  n_vc = r_vc;  n_pos = r_pos;
        n_npc = r_npc;  n_rem = r_rem;  n_prod = r_prod;  n_k = r_k;
        n_stop = r_stop;  n_ins = r_ins;  n_cov_done = r_cov_done;
        n_cov_ok = r_cov_ok;  n_found = r_found;  n_have_prev = r_have_prev;
        n_prev = r_prev;
        o_ctl = '0;
        o_piece = i_head;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_res = '0;
                    n_s = {1'b0, i_req.req_addr};
                    n_cs = {1'b0, i_req.req_addr};
                    n_e = sum;
                    n_pos = '0;
                    n_npc = (i_req.req_type == REQ_ADD) ? CNT_W'(1) : '0;
                    n_stop = 1'b0;
                    n_cov_done = 1'b0;
                    n_cov_ok = 1'b0;
                    n_found = 1'b0;
                    n_have_prev = 1'b0;
                    if (early) begin
                        n_res.status = code;
                        n_valid = 1'b1;
                    end else begin
                        n_state = S_DRY;
                    end
                end
            end
            // Rotate the whole table once, counting pieces and searching.
            S_DRY: begin
                if (r_pos != r_vc) begin
                    o_ctl = '{pop: 1'b1, app: 1'b1, widx: r_vc};
                    n_pos = r_pos + CNT_W'(1);
                    n_npc = r_npc + CNT_W'(c_np);
                    n_s = c_s_next;
                    n_stop = c_stop_next;
                    n_have_prev = 1'b1;
                    n_prev = pe_r;
                    if (r_req.req_type == REQ_PROT && !r_cov_done) begin
                        if (r_cs >= w_pe) begin
                            n_cs = r_cs;
                        end else if (r_cs < w_base ||
                                     (r_req.prot_bits & ~max_prot(i_head.attrs)) != 3'd0)
                        begin
                            n_cov_done = 1'b1;
                        end else if (w_pe >= r_e) begin
                            n_cov_done = 1'b1;
                            n_cov_ok = 1'b1;
                        end else begin
                            n_cs = w_pe;
                        end
                    end
                    if (r_req.req_type == REQ_PAGE && !r_found &&
                        w_base <= r_s && r_s < w_pe) begin
                        n_found = 1'b1;
                        n_res.result_addr = i_head.base;
                        n_res.region_length = i_head.size;
                        n_res.region_prot = i_head.attrs[2:0];
                        n_res.region_flags = i_head.attrs[10:3];
                        n_res.region_desc = i_head.attrs[18:11];
                        n_res.region_offset = i_head.off;
                        n_res.region_file_size = i_head.fsz;
                    end
                    if (r_req.req_type == REQ_TOP && r_have_prev && cb > r_prev &&
                        cb - r_prev >= {2'b0, r_req.length_bytes}) begin
                        n_found = 1'b1;
                        n_res.result_addr = cb[31:0] - r_req.length_bytes;
                    end
                    if (r_req.req_type == REQ_ABOVE && !r_found && r_have_prev &&
                        cb > r_prev && cb > {1'b0, r_s} &&
                        cb - sp >= {2'b0, r_req.length_bytes}) begin
                        n_found = 1'b1;
                        n_res.result_addr = sp[31:0];
                    end
                end else begin
                    n_rem = r_vc;
                    n_prod = '0;
                    n_k = 2'd0;
                    n_stop = 1'b0;
                    n_s = {1'b0, r_req.req_addr};
                    n_ins = (r_req.req_type == REQ_ADD);
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    case (r_req.req_type)
                        REQ_ADD, REQ_REM: begin
                            if (r_npc > CNT_W'(TABLE_ENTRIES)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_state = S_WET;
                                n_valid = 1'b0;
                            end
                        end
                        REQ_PROT: begin
                            if (!r_cov_ok) begin
                                n_res.status = ST_NONE;
                            end else if (r_req.length_bytes == 32'd0) begin
                                n_res.status = ST_OK;
                            end else if (r_npc > CNT_W'(TABLE_ENTRIES)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_state = S_WET;
                                n_valid = 1'b0;
                            end
                        end
                        default: begin
                            n_res.status = r_found ? ST_OK : ST_NONE;
                        end
                    endcase
                end
            end
            // Rebuild: pop each old entry and append its pieces at the tail.
            S_WET: begin
                if (r_rem == '0) begin
                    if (r_ins) begin
                        o_ctl = '{pop: 1'b0, app: 1'b1, widx: r_prod};
                        o_piece = w_new;
                        n_prod = r_prod + CNT_W'(1);
                        n_ins = 1'b0;
                    end else begin
                        n_vc = r_prod;
                        n_res.status = (r_req.req_type == REQ_REM && r_vc != '0 &&
                                        r_prod == '0) ? ST_EMPTIED : ST_OK;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (c_np == 2'd0) begin
                    o_ctl = '{pop: 1'b1, app: 1'b0, widx: '0};
                    n_rem = r_rem - CNT_W'(1);
                    n_s = c_s_next;
                    n_stop = c_stop_next;
                end else if (r_ins && c_sel.base > r_req.req_addr) begin
                    o_ctl = '{pop: 1'b0, app: 1'b1, widx: r_rem + r_prod};
                    o_piece = w_new;
                    n_prod = r_prod + CNT_W'(1);
                    n_ins = 1'b0;
                end else begin
                    o_piece = c_sel;
                    n_prod = r_prod + CNT_W'(1);
                    if (r_k == c_np - 2'd1) begin
                        o_ctl = '{pop: 1'b1, app: 1'b1, widx: r_rem + r_prod};
                        n_rem = r_rem - CNT_W'(1);
                        n_k = 2'd0;
                        n_s = c_s_next;
                        n_stop = c_stop_next;
                    end else begin
                        o_ctl = '{pop: 1'b0, app: 1'b1, widx: r_rem + r_prod};
                        n_k = r_k + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state is reset; working values are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_vc    <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_vc    <= n_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;  r_res <= n_res;  r_s <= n_s;  r_e <= n_e;  r_cs <= n_cs;
        r_pos <= n_pos;  r_npc <= n_npc;  r_rem <= n_rem;  r_prod <= n_prod;
        r_k <= n_k;  r_stop <= n_stop;  r_ins <= n_ins;  r_cov_done <= n_cov_done;
        r_cov_ok <= n_cov_ok;  r_found <= n_found;  r_have_prev <= n_have_prev;
        r_prev <= n_prev;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- tb/sv/region_map_table_checker.sv -----
module region_map_table_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  rmte_pkg::t_req i_req,
    input  logic           o_valid,
    input  rmte_pkg::t_res o_res,
    input  logic           i_cfg_we,
    input  logic [4:0]     i_cfg_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import rmte_pkg::*;

    typedef bit [63:0] u64;

    typedef struct {
        u64          base;
        u64          size;
        logic [20:0] at;
        logic [47:0] off;
        logic [47:0] fsz;
    } t_piece;

    localparam int SCRATCH = TABLE_ENTRIES + 2;

    // Model copy of the region table and the page shift register.
    logic [31:0] tbl_base [TABLE_ENTRIES];
    logic [31:0] tbl_size [TABLE_ENTRIES];
    logic [20:0] tbl_attr [TABLE_ENTRIES];
    logic [47:0] tbl_off  [TABLE_ENTRIES];
    logic [47:0] tbl_fsz  [TABLE_ENTRIES];
    int          n_regions;
    logic [4:0]  shift_reg;

    // Pieces of the table under reconstruction.
    t_piece pieces [SCRATCH];
    int     n_pieces;

    t_res expected_q [$];

    function automatic void add_piece(u64 b, u64 sz, logic [20:0] at, u64 off, u64 fsz);
        if (n_pieces < SCRATCH) begin
            pieces[n_pieces].base = b;
            pieces[n_pieces].size = sz;
            pieces[n_pieces].at   = at;
            pieces[n_pieces].off  = off[47:0];
            pieces[n_pieces].fsz  = fsz[47:0];
        end
        n_pieces++;
    endfunction

    function automatic t_piece region_at(int i);
        t_piece p;
        p.base = tbl_base[i];
        p.size = tbl_size[i];
        p.at   = tbl_attr[i];
        p.off  = tbl_off[i];
        p.fsz  = tbl_fsz[i];
        return p;
    endfunction

    // Sort the pieces by base and make them the table.
    function automatic void install_pieces();
        t_piece k;
        int j;
        for (int i = 1; i < n_pieces; i++) begin
            k = pieces[i];
            j = i;
            while (j > 0 && pieces[j-1].base > k.base) begin
                pieces[j] = pieces[j-1];
                j--;
            end
            pieces[j] = k;
        end
        for (int i = 0; i < n_pieces; i++) begin
            tbl_base[i] = pieces[i].base[31:0];
            tbl_size[i] = pieces[i].size[31:0];
            tbl_attr[i] = pieces[i].at;
            tbl_off[i]  = pieces[i].off;
            tbl_fsz[i]  = pieces[i].fsz;
        end
        n_regions = n_pieces;
    endfunction

    function automatic logic [2:0] prot_limit(logic [20:0] at);
        if (at[18:11] != 8'd0 && !at[4]) begin
            case (at[20:19])
                2'd0:    return 3'd1;
                2'd1:    return 3'd2;
                2'd2:    return 3'd3;
                default: return 3'd0;
            endcase
        end
        return 3'd3;
    endfunction

    function automatic u64 map_round(u64 x);
        u64 m;
        m = (u64'(1) << MAP_PAGE_SHIFT) - 1;
        return (x + m) & ~m;
    endfunction

    // Cut [s, e) out of every region, optionally inserting the new one.
    function automatic logic [2:0] cut_out(u64 s, u64 e, bit ins, t_piece nw);
        t_piece p;
        u64 pe;
        bit stop;
        bit emptied;
        stop = 0;
        n_pieces = 0;
        for (int i = 0; i < n_regions; i++) begin
            p = region_at(i);
            pe = p.base + p.size;
            if (stop) begin
                add_piece(p.base, p.size, p.at, p.off, p.fsz);
            end else if (p.base < s && e < pe) begin
                add_piece(p.base, s - p.base, p.at, p.off, p.fsz);
                add_piece(e, pe - e, p.at, p.off + (e - p.base), p.fsz);
                stop = 1;
            end else if (p.base < s && s < pe) begin
                add_piece(p.base, s - p.base, p.at, p.off, p.fsz);
            end else if (p.base < e && e < pe) begin
                add_piece(e, pe - e, p.at, p.off + (e - p.base), p.fsz);
                stop = 1;
            end else if (!(s <= p.base && pe <= e)) begin
                add_piece(p.base, p.size, p.at, p.off, p.fsz);
            end
        end
        if (ins) add_piece(nw.base, nw.size, nw.at, nw.off, nw.fsz);
        if (n_pieces > TABLE_ENTRIES) return ST_FULL;
        emptied = n_regions > 0 && n_pieces == 0;
        install_pieces();
        return emptied ? ST_EMPTIED : ST_OK;
    endfunction

    // Check coverage and permission, then split and relabel.
    function automatic logic [2:0] reprotect(u64 s, u64 e, logic [2:0] prot);
        t_piece p;
        u64 pe;
        u64 cs;
        u64 nb;
        logic [20:0] na;
        bit ok;
        bit stop;
        cs = s;
        ok = 0;
        stop = 0;
        for (int i = 0; i < n_regions; i++) begin
            p = region_at(i);
            pe = p.base + p.size;
            if (cs >= pe) continue;
            if (cs < p.base) return ST_NONE;
            if ((prot & ~prot_limit(p.at)) != 0) return ST_NONE;
            if (pe >= e) begin
                ok = 1;
                break;
            end
            cs = pe;
        end
        if (!ok) return ST_NONE;
        nb = e - s;
        if (nb == 0) return ST_OK;
        n_pieces = 0;
        for (int i = 0; i < n_regions; i++) begin
            p = region_at(i);
            pe = p.base + p.size;
            na = {p.at[20:3], prot};
            if (stop || nb == 0) begin
                add_piece(p.base, p.size, p.at, p.off, p.fsz);
            end else if (p.base < s && e < pe) begin
                add_piece(p.base, s - p.base, p.at, p.off, p.fsz);
                add_piece(e, pe - e, p.at, p.off + (e - p.base), p.fsz);
                add_piece(s, nb, na, p.off + (s - p.base), p.fsz);
                stop = 1;
            end else if (p.base < s && s < pe) begin
                add_piece(p.base, s - p.base, p.at, p.off, p.fsz);
                add_piece(s, pe - s, na, p.off + (s - p.base), p.fsz);
                s = pe;
                nb = e - pe;
            end else if (p.base < e && e < pe) begin
                add_piece(s, nb, na, p.off, p.fsz);
                add_piece(e, pe - e, p.at, p.off + (e - p.base), p.fsz);
                stop = 1;
            end else if (s <= p.base && pe <= e) begin
                add_piece(p.base, p.size, na, p.off, p.fsz);
                s = pe;
                nb = e - pe;
            end else begin
                add_piece(p.base, p.size, p.at, p.off, p.fsz);
            end
        end
        if (n_pieces > TABLE_ENTRIES) return ST_FULL;
        install_pieces();
        return ST_OK;
    endfunction

    // Work out the answer to one request and update the model table.
    function automatic t_res region_answer(t_req r);
        t_res   res;
        t_piece nw;
        u64 s, len, pmask, mmask, pe, cb, sp;
        bit bad, bad_map;
        res = '0;
        res.status = ST_NONE;
        s = r.req_addr;
        len = r.length_bytes;
        pmask = (u64'(1) << shift_reg) - 1;
        mmask = (u64'(1) << MAP_PAGE_SHIFT) - 1;
        bad = ((s & pmask) != 0) || ((len & pmask) != 0);
        bad_map = len == 0 || (len & mmask) != 0;
        nw.base = s;
        nw.size = len;
        nw.at   = {r.desc_access, r.desc_id, r.map_flags, r.prot_bits};
        nw.off  = r.file_offset;
        nw.fsz  = r.backing_size;
        case (r.req_type)
            REQ_ADD: begin
                if (bad || len == 0 || s + len > (u64'(1) << 32)) res.status = ST_MISALIGN;
                else res.status = cut_out(s, s + len, 1, nw);
            end
            REQ_REM: begin
                if (bad || len == 0) res.status = ST_MISALIGN;
                else res.status = cut_out(s, s + len, 0, nw);
            end
            REQ_PROT: begin
                res.status = bad ? ST_MISALIGN : reprotect(s, s + len, r.prot_bits);
            end
            REQ_PAGE: begin
                if ((s & pmask) != 0) begin
                    res.status = ST_MISALIGN;
                end else begin
                    for (int i = 0; i < n_regions; i++) begin
                        if (tbl_base[i] <= s && s < u64'(tbl_base[i]) + tbl_size[i]) begin
                            res.status           = ST_OK;
                            res.result_addr      = tbl_base[i];
                            res.region_length    = tbl_size[i];
                            res.region_prot      = tbl_attr[i][2:0];
                            res.region_flags     = tbl_attr[i][10:3];
                            res.region_desc      = tbl_attr[i][18:11];
                            res.region_offset    = tbl_off[i];
                            res.region_file_size = tbl_fsz[i];
                            break;
                        end
                    end
                end
            end
            REQ_TOP: begin
                if (bad_map) begin
                    res.status = ST_MISALIGN;
                end else begin
                    for (int i = n_regions; i > 1; i--) begin
                        pe = map_round(u64'(tbl_base[i-2]) + tbl_size[i-2]);
                        cb = u64'(tbl_base[i-1]) & ~mmask;
                        if (cb <= pe) continue;
                        if (cb - pe >= len) begin
                            res.status = ST_OK;
                            res.result_addr = 32'(cb - len);
                            break;
                        end
                    end
                end
            end
            REQ_ABOVE: begin
                if (bad_map || (s & mmask) != 0) begin
                    res.status = ST_MISALIGN;
                end else begin
                    for (int i = 1; i < n_regions; i++) begin
                        pe = map_round(u64'(tbl_base[i-1]) + tbl_size[i-1]);
                        cb = u64'(tbl_base[i]) & ~mmask;
                        if (cb <= pe || cb <= s) continue;
                        sp = s > pe ? s : pe;
                        if (cb - sp >= len) begin
                            res.status = ST_OK;
                            res.result_addr = 32'(sp);
                            break;
                        end
                    end
                end
            end
            default: res.status = ST_NONE;
        endcase
        return res;
    endfunction

    function automatic int field_differs(string name, u64 exp_v, u64 act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Compare answers first, then predict the request accepted at this edge.
    always @(posedge i_clk) begin
        t_res e;
        int bad;
        if (!i_rst_n) begin
            n_regions = 0;
            shift_reg <= 5'd12;
            expected_q.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (o_valid) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    $error("answer with no request outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    bad = field_differs("status", e.status, o_res.status)
                        + field_differs("result_addr", e.result_addr, o_res.result_addr)
                        + field_differs("region_length", e.region_length, o_res.region_length)
                        + field_differs("region_prot", e.region_prot, o_res.region_prot)
                        + field_differs("region_flags", e.region_flags, o_res.region_flags)
                        + field_differs("region_desc", e.region_desc, o_res.region_desc)
                        + field_differs("region_offset", e.region_offset, o_res.region_offset)
                        + field_differs("region_file_size", e.region_file_size,
                                        o_res.region_file_size);
                    if (bad != 0) o_errors <= o_errors + 1;
                end
            end
            if (start && !busy) expected_q.push_back(region_answer(i_req));
            if (i_cfg_we) shift_reg <= i_cfg_data;
        end
    end

    assign o_pending = expected_q.size();

endmodule

// ----- tb/sv/region_map_table_engine_test.sv -----
module region_map_table_engine_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rmte_pkg::*;

    // Codes outside the request set.
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       start = 0;
    logic       busy;
    t_req       i_req = '0;
    logic       o_valid;
    t_res       o_res;
    logic       i_cfg_we = 0;
    logic [4:0] i_cfg_data = 5'd12;
    int         n_errors, n_pending, n_answers;
    int         n_sent = 0;
    int         quiet_cycles = 0;
    int         cur_shift = 12;

    always #5 i_clk = ~i_clk;

    region_map_table_engine uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_req     (i_req),
        .o_valid   (o_valid),
        .o_res     (o_res),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    region_map_table_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_req     (i_req),
        .o_valid   (o_valid),
        .o_res     (o_res),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_errors  (n_errors),
        .o_pending (n_pending),
        .o_results (n_answers)
    );

    // Watchdog on cycles with no request accepted and no answer.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d answers outstanding", n_pending);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one request and hold it until the engine takes it.
    task automatic send(t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(0, 99) < 22) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_shift(int sh);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 5'(sh);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_shift = sh;
    endtask

    function automatic t_req make_req(logic [2:0] op, logic [31:0] a, logic [31:0] len,
                                      logic [2:0] prot, logic [7:0] fl, logic [7:0] d,
                                      logic [1:0] acc);
        t_req r;
        r.req_type     = op;
        r.req_addr     = a;
        r.length_bytes = len;
        r.prot_bits    = prot;
        r.map_flags    = fl;
        r.desc_id      = d;
        r.desc_access  = acc;
        r.file_offset  = {$urandom, $urandom};
        r.backing_size = {$urandom, $urandom};
        return r;
    endfunction

    // Mostly page-aligned requests in a crowded window, some pure noise.
    function automatic t_req random_req();
        t_req r;
        int pick;
        pick = $urandom_range(0, 99);
        r.req_type = pick < 40 ? REQ_ADD : pick < 52 ? REQ_REM : pick < 67 ? REQ_PROT :
                     pick < 82 ? REQ_PAGE : pick < 90 ? REQ_TOP : pick < 98 ? REQ_ABOVE :
                     (pick == 98 ? REQ_SPARE_LO : REQ_SPARE_HI);
        r.prot_bits    = 3'($urandom);
        r.map_flags    = 8'($urandom);
        r.desc_id      = $urandom_range(0, 9) < 3 ? 8'd0 : 8'($urandom);
        r.desc_access  = 2'($urandom);
        r.file_offset  = {$urandom, $urandom};
        r.backing_size = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            r.req_addr     = $urandom;
            r.length_bytes = $urandom;
        end else begin
            r.req_addr = (pick < 20 ? 32'hFFC0_0000 : 32'h0)
                       + (32'($urandom_range(0, 63)) << 16);
            if ($urandom_range(0, 1)) r.req_addr += 32'($urandom_range(0, 15)) << cur_shift;
            r.length_bytes = $urandom_range(0, 1) ? 32'($urandom_range(1, 8)) << 16
                                                  : 32'($urandom_range(1, 8)) << cur_shift;
        end
        return r;
    endfunction

    initial begin
        int shifts[5] = '{16, 13, 15, 14, 12};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_shift(12);

        // Directed requests: splits, permission limits, edge statuses.
        send(make_req(REQ_ADD, 32'h0001_0000, 32'h0003_0000, 3'd1, 8'h00, 8'd5, 2'd0));
        send(make_req(REQ_ADD, 32'h0002_0000, 32'h0000_1000, 3'd7, 8'h02, 8'd0, 2'd3));
        send(make_req(REQ_PAGE, 32'h0001_0000, '0, '0, '0, '0, '0));
        send(make_req(REQ_PAGE, 32'h0002_1000, '0, '0, '0, '0, '0));
        send(make_req(REQ_PAGE, 32'h0005_0000, '0, '0, '0, '0, '0));
        send(make_req(REQ_PROT, 32'h0001_0000, 32'h0001_0000, 3'd2, '0, '0, '0));
        send(make_req(REQ_PROT, 32'h0001_0000, 32'h0, 3'd1, '0, '0, '0));
        send(make_req(REQ_PROT, 32'h0003_0000, 32'h0001_0000, 3'd1, '0, '0, '0));
        send(make_req(REQ_PROT, 32'h0000_0000, 32'h0002_0000, 3'd1, '0, '0, '0));
        send(make_req(REQ_ADD, 32'h0001_0001, 32'h0000_1000, 3'd1, '0, '0, '0));
        send(make_req(REQ_ADD, 32'h0006_0000, 32'h0, 3'd1, '0, '0, '0));
        send(make_req(REQ_ADD, 32'hFFFF_0000, 32'h0002_0000, 3'd1, '0, '0, '0));
        send(make_req(REQ_ADD, 32'hFFFF_F000, 32'h0000_1000, 3'd7, 8'hFF, 8'hFF, 2'd3));
        send(make_req(REQ_TOP, '0, 32'h0001_0000, '0, '0, '0, '0));
        send(make_req(REQ_TOP, '0, 32'h0, '0, '0, '0, '0));
        send(make_req(REQ_ABOVE, 32'h0, 32'h0001_0000, '0, '0, '0, '0));
        send(make_req(REQ_ABOVE, 32'h0000_1000, 32'h0001_0000, '0, '0, '0, '0));
        send(make_req(REQ_SPARE_LO, '0, '0, '0, '0, '0, '0));
        send(make_req(REQ_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 8'hFF, 8'hFF, 2'd3));
        send(make_req(REQ_REM, 32'h0, 32'hFFFF_F000, '0, '0, '0, '0));
        send(make_req(REQ_REM, 32'hFFFF_F000, 32'h0000_1000, '0, '0, '0, '0));
        send(make_req(REQ_REM, 32'h0, 32'h0001_0000, '0, '0, '0, '0));

        // Random phases, one per page shift; one phase with no idling.
        for (int ph = 0; ph < 5; ph++) begin
            write_shift(shifts[ph]);
            for (int k = 0; k < 140; k++) begin
                send(random_req());
                if (ph == 2 && k == 70) drain();
                maybe_idle(ph != 1);
            end
        end

        drain();
        $display("Sent %0d requests and checked %0d answers over page shifts 12 to 16,",
                 n_sent, n_answers);
        $display("including splits, full and emptied tables and gap searches.");
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
